// ===== rtl/wfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wfd_pkg
// Shared constants, request/response types and the CORDIC arctangent table
// for the windowed-sinc low-pass FIR designer.
// ----------------------------------------------------------------------------
`default_nettype none

package wfd_pkg;

  // Default parameter values
  localparam int HALF_MAX_DEF         = 31;
  localparam int QUANT_SCALE_LOG2_DEF = 8;

  // Fixed-point constants
  localparam int ONE_Q22     = 4194304;
  localparam int ONE_Q30     = 1073741824;
  localparam int CORDIC_GAIN = 652032874;
  localparam logic [31:0] INV_PI_Q32 = 32'd1367130551;

  // CORDIC geometry: angle full turn is 2^23
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_KW    = 5;
  localparam int CORDIC_W     = 33;
  localparam int ANGLE_W      = 23;
  localparam int ZW           = 25;

  // Bit-serial divider geometry
  localparam int DIV_NW = 56;
  localparam int DIV_DW = 32;
  localparam int DIV_CW = 6;

  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] nbits;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [ANGLE_W-1:0] angle;
  } cor_req_t;

  typedef struct packed {
    logic                done;
    logic [CORDIC_W-1:0] cos_v;
    logic [CORDIC_W-1:0] sin_v;
  } cor_rsp_t;

  // Arctangent of 2^-k, scaled so that 2^22 is pi
  function automatic logic signed [ZW-1:0] cordic_atan(input logic [CORDIC_KW-1:0] k);
    logic signed [ZW-1:0] v;
    case (k)
      5'd0:    v = 25'sd1048576;
      5'd1:    v = 25'sd619011;
      5'd2:    v = 25'sd327068;
      5'd3:    v = 25'sd166025;
      5'd4:    v = 25'sd83335;
      5'd5:    v = 25'sd41708;
      5'd6:    v = 25'sd20859;
      5'd7:    v = 25'sd10430;
      5'd8:    v = 25'sd5215;
      5'd9:    v = 25'sd2608;
      5'd10:   v = 25'sd1304;
      5'd11:   v = 25'sd652;
      5'd12:   v = 25'sd326;
      5'd13:   v = 25'sd163;
      5'd14:   v = 25'sd81;
      5'd15:   v = 25'sd41;
      5'd16:   v = 25'sd20;
      5'd17:   v = 25'sd10;
      5'd18:   v = 25'sd5;
      5'd19:   v = 25'sd3;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/wfd_ram.sv =====
// ----------------------------------------------------------------------------
// wfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 63
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/wfd_div.sv =====
// ----------------------------------------------------------------------------
// wfd_div
// Unsigned restoring divider, one quotient bit per cycle. The numerator is
// handed in left-aligned; nbits sets how many quotient bits are produced.
// ----------------------------------------------------------------------------
`default_nettype none

module wfd_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire wfd_pkg::div_req_t req,
  output wfd_pkg::div_rsp_t      rsp
);

  localparam int NW = wfd_pkg::DIV_NW;
  localparam int DW = wfd_pkg::DIV_DW;
  localparam int CW = wfd_pkg::DIV_CW;

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] nr_r;
  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fit;

  // Shift in the next numerator bit and try a subtract
  assign trial = {rem_r, nr_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fit   = (trial >= {1'b0, den_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      nr_r  <= req.num;
      den_r <= req.den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      nr_r  <= {nr_r[NW-2:0], 1'b0};
      q_r   <= {q_r[NW-2:0], fit};
      rem_r <= fit ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

`default_nettype wire

// ===== rtl/wfd_cordic.sv =====
// ----------------------------------------------------------------------------
// wfd_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, giving cos and sin
// in Q2.30 for an angle where 2^23 is a full turn.
// ----------------------------------------------------------------------------
`default_nettype none

module wfd_cordic (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire wfd_pkg::cor_req_t req,
  output wfd_pkg::cor_rsp_t      rsp
);

  localparam int W  = wfd_pkg::CORDIC_W;
  localparam int ZW = wfd_pkg::ZW;
  localparam int KW = wfd_pkg::CORDIC_KW;
  localparam int AW = wfd_pkg::ANGLE_W;

  localparam logic [AW-1:0]        QTR_LO    = AW'(23'h200000);
  localparam logic [AW-1:0]        QTR_HI    = AW'(23'h600000);
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(4194304);
  localparam logic signed [ZW-1:0] FULL_TURN = ZW'(8388608);

  logic                 busy_r;
  logic                 done_r;
  logic                 flip_r;
  logic [KW-1:0]        k_r;
  logic signed [W-1:0]  x_r;
  logic signed [W-1:0]  y_r;
  logic signed [ZW-1:0] z_r;
  logic signed [ZW-1:0] z_in;
  logic                 flip_in;
  logic signed [W-1:0]  dx;
  logic signed [W-1:0]  dy;
  logic signed [ZW-1:0] at;

  // Fold the angle into the right half plane
  always_comb begin
    if (req.angle >= QTR_LO && req.angle < QTR_HI) begin
      z_in    = $signed({2'b00, req.angle}) - HALF_TURN;
      flip_in = 1'b1;
    end else if (req.angle >= QTR_HI) begin
      z_in    = $signed({2'b00, req.angle}) - FULL_TURN;
      flip_in = 1'b0;
    end else begin
      z_in    = $signed({2'b00, req.angle});
      flip_in = 1'b0;
    end
  end

  assign dx = y_r >>> k_r;
  assign dy = x_r >>> k_r;
  assign at = wfd_pkg::cordic_atan(k_r);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (busy_r) begin
        k_r <= k_r + 1'b1;
        if (k_r == KW'(wfd_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r    <= W'(wfd_pkg::CORDIC_GAIN);
      y_r    <= '0;
      z_r    <= z_in;
      flip_r <= flip_in;
    end else if (busy_r) begin
      if (!z_r[ZW-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.cos_v = flip_r ? -x_r : x_r;
  assign rsp.sin_v = flip_r ? -y_r : y_r;

endmodule

`default_nettype wire

// ===== rtl/windowed_sinc_fir_designer.sv =====
// ----------------------------------------------------------------------------
// windowed_sinc_fir_designer
// Designs a Hann-windowed sinc low-pass FIR and streams out its taps.
// ----------------------------------------------------------------------------
// Usage:
//   One request beat (sample rate, cutoff, half length R) yields 2R+1
//   quantized taps, trimmed of matching zero ends, one beat per tap with
//   tap_index, tap_count and last_tap. A zero sample rate yields a single
//   beat with bad_request set. A new request is taken only after the last
//   beat of the previous one has been taken.
// Sequence:
//   A step division first, then per tap in pass one, where needed, two
//   20-step CORDIC runs, a 47-step sinc division and a 28-step window
//   angle division, all on shared sequential units, and in pass two a
//   normalizing divide. Each result beat is a RAM read plus an output
//   register load.
// Reset:
//   rst_n clears the controller and the output valid; the tap RAMs need no
//   clearing since every request writes what it reads.
// Stall:
//   The output register holds its beat until out_ready; work pauses there.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_sinc_fir_designer #(
  parameter int HALF_MAX         = wfd_pkg::HALF_MAX_DEF,
  parameter int QUANT_SCALE_LOG2 = wfd_pkg::QUANT_SCALE_LOG2_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [31:0]        in_sample_rate,
  input  wire logic [31:0]        in_cutoff_freq,
  input  wire logic [4:0]         in_half_length,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_tap_value,
  output logic [5:0]              out_tap_index,
  output logic [5:0]              out_tap_count,
  output logic                    out_last_tap,
  output logic                    out_bad_request
);

  localparam int TAP_DEPTH = 2 * HALF_MAX + 1;
  localparam int AW        = $clog2(TAP_DEPTH);
  localparam int NW        = wfd_pkg::DIV_NW;
  localparam int DW        = wfd_pkg::DIV_DW;
  localparam int CW        = wfd_pkg::DIV_CW;
  localparam int XW        = 31;
  localparam int CWID      = 28;
  localparam int SW        = 31;
  localparam int STEP_NB   = 55;
  localparam int SD_NB     = 47;
  localparam int WD_NB     = 28;
  localparam int QNB       = ((24 + QUANT_SCALE_LOG2) > 30 ? (24 + QUANT_SCALE_LOG2) : 30) + 1;
  localparam logic signed [23:0] TAP24_MAX = 24'sd8388607;
  localparam logic signed [23:0] TAP24_MIN = -24'sd8388608;

  typedef enum logic [4:0] {
    S_IDLE, S_STEP_GO, S_STEP_WAIT, S_X_MUL, S_SC_GO, S_SC_WAIT, S_SC_MUL,
    S_SD_GO, S_SD_WAIT, S_WD_GO, S_WD_WAIT, S_WC_GO, S_WC_WAIT, S_CW_MUL,
    S_CW_WR, S_Q_RD, S_Q_GO, S_Q_WAIT, S_Q_WR, S_TRIM, S_E_RD, S_E_WAIT,
    S_E_OUT
  } state_t;

  state_t                 state_r;
  logic [31:0]            fs_r;
  logic [31:0]            fc_r;
  logic [4:0]             rr_r;
  logic [5:0]             n_r;
  logic [5:0]             i_r;
  logic [23:0]            step_r;
  logic signed [XW-1:0]   x_r;
  logic signed [32:0]     sn_r;
  logic signed [47:0]     sp_r;
  logic                   neg_r;
  logic signed [CWID-1:0] c_r;
  logic [22:0]            angle_r;
  logic [23:0]            w_r;
  logic signed [23:0]     cw_r;
  logic signed [SW-1:0]   sum_r;
  logic [15:0]            qv_r;
  logic                   any_r;
  logic [5:0]             f_r;
  logic [5:0]             l_r;
  logic [5:0]             base_r;
  logic [5:0]             idx_r;
  logic [5:0]             cnt_r;
  logic                   out_valid_r;
  logic [15:0]            out_tap_value_r;
  logic [5:0]             out_tap_index_r;
  logic [5:0]             out_tap_count_r;
  logic                   out_last_tap_r;
  logic                   out_bad_request_r;

  wfd_pkg::div_req_t div_req;
  wfd_pkg::div_rsp_t div_rsp;
  wfd_pkg::cor_req_t cor_req;
  wfd_pkg::cor_rsp_t cor_rsp;

  logic [23:0]            tb_rdata;
  logic [15:0]            qb_rdata;
  logic [5:0]             e_addr;

  // Shared arithmetic units
  wfd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  wfd_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .rsp   (cor_rsp)
  );

  // Windowed taps and quantized taps
  wfd_ram #(.WIDTH(24), .DEPTH(TAP_DEPTH)) u_tap_ram (
    .clk   (clk),
    .we    (state_r == S_CW_WR),
    .waddr (i_r[AW-1:0]),
    .wdata (cw_r),
    .raddr (i_r[AW-1:0]),
    .rdata (tb_rdata)
  );

  assign e_addr = base_r + idx_r;

  wfd_ram #(.WIDTH(16), .DEPTH(TAP_DEPTH)) u_q_ram (
    .clk   (clk),
    .we    (state_r == S_Q_WR),
    .waddr (i_r[AW-1:0]),
    .wdata (qv_r),
    .raddr (e_addr[AW-1:0]),
    .rdata (qb_rdata)
  );

  // Sample offset times step
  logic signed [6:0]    di;
  logic signed [XW-1:0] di_ext;
  logic signed [XW-1:0] st_ext;
  logic signed [XW-1:0] x_nxt;
  assign di     = $signed({1'b0, i_r}) - $signed({2'b00, rr_r});
  assign di_ext = XW'(di);
  assign st_ext = $signed({{(XW - 24){1'b0}}, step_r});
  assign x_nxt  = di_ext * st_ext;

  // sin times 1/pi
  logic signed [65:0] spa;
  logic signed [65:0] spb;
  logic signed [65:0] spp;
  assign spa = 66'(sn_r);
  assign spb = $signed({34'd0, wfd_pkg::INV_PI_Q32});
  assign spp = spa * spb;

  // Magnitudes for the sinc division
  logic [47:0] sp_mag;
  logic [XW-1:0] x_mag;
  assign sp_mag = sp_r[47] ? 48'(-sp_r) : 48'(sp_r);
  assign x_mag  = x_r[XW-1] ? XW'(-x_r) : XW'(x_r);

  // Hann window from cos
  logic signed [34:0] wt;
  assign wt = 35'(wfd_pkg::ONE_Q30) - 35'($signed(cor_rsp.cos_v)) + 35'sd256;

  // Windowed tap
  logic signed [52:0] cwa;
  logic signed [52:0] cwb;
  logic signed [52:0] cwp;
  logic signed [30:0] cws;
  logic signed [23:0] cw_nxt;
  assign cwa = 53'(c_r);
  assign cwb = $signed({29'd0, w_r});
  assign cwp = cwa * cwb;
  assign cws = $signed(cwp[52:22]);
  always_comb begin
    if (cws > 31'(TAP24_MAX)) begin
      cw_nxt = TAP24_MAX;
    end else if (cws < 31'(TAP24_MIN)) begin
      cw_nxt = TAP24_MIN;
    end else begin
      cw_nxt = cws[23:0];
    end
  end

  // Normalizing divide operands: (2|t|*2^Q + |s|) / (2|s|)
  logic signed [23:0] tap_s;
  logic [23:0]        tap_mag;
  logic [SW-1:0]      sum_mag;
  logic [QNB-1:0]     qnum;
  assign tap_s   = $signed(tb_rdata);
  assign tap_mag = tap_s[23] ? 24'(-tap_s) : 24'(tap_s);
  assign sum_mag = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign qnum    = (QNB'(tap_mag) << (QUANT_SCALE_LOG2 + 1)) + QNB'(sum_mag);

  // Saturate the quantized tap
  logic [15:0] qv_nxt;
  always_comb begin
    if (!neg_r) begin
      qv_nxt = (div_rsp.quot > NW'(32767)) ? 16'h7FFF : div_rsp.quot[15:0];
    end else begin
      qv_nxt = (div_rsp.quot > NW'(32768)) ? 16'h8000 : 16'(-div_rsp.quot[15:0]);
    end
  end

  // Trim bounds
  logic [5:0] back;
  logic [5:0] j_min;
  assign back  = n_r - 6'd1 - l_r;
  assign j_min = (f_r < back) ? f_r : back;

  // Divider requests
  always_comb begin
    div_req = '0;
    case (state_r)
      S_STEP_GO: begin
        div_req.start = 1'b1;
        div_req.nbits = CW'(STEP_NB);
        div_req.num   = NW'({fc_r, 23'd0}) << (NW - STEP_NB);
        div_req.den   = fs_r;
      end
      S_SD_GO: begin
        div_req.start = 1'b1;
        div_req.nbits = CW'(SD_NB);
        div_req.num   = NW'(sp_mag[SD_NB-1:0]) << (NW - SD_NB);
        div_req.den   = DW'(x_mag);
      end
      S_WD_GO: begin
        div_req.start = (rr_r != 5'd0);
        div_req.nbits = CW'(WD_NB);
        div_req.num   = NW'({i_r, 22'd0}) << (NW - WD_NB);
        div_req.den   = DW'(rr_r);
      end
      S_Q_GO: begin
        div_req.start = (sum_r != '0);
        div_req.nbits = CW'(QNB);
        div_req.num   = NW'(qnum) << (NW - QNB);
        div_req.den   = DW'({sum_mag, 1'b0});
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // CORDIC requests
  assign cor_req.start = ((state_r == S_SC_GO) && (x_r != '0)) || (state_r == S_WC_GO);
  assign cor_req.angle = (state_r == S_WC_GO) ? angle_r : x_r[22:0];

  // Controller with registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      idx_r       <= '0;
      any_r       <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_sample_rate == 32'd0) begin
              out_tap_value_r   <= '0;
              out_tap_index_r   <= '0;
              out_tap_count_r   <= '0;
              out_last_tap_r    <= 1'b1;
              out_bad_request_r <= 1'b1;
              out_valid_r       <= 1'b1;
              state_r           <= S_E_OUT;
            end else begin
              fs_r    <= in_sample_rate;
              fc_r    <= in_cutoff_freq;
              rr_r    <= (in_half_length > 5'(HALF_MAX)) ? 5'(HALF_MAX) : in_half_length;
              n_r     <= (in_half_length > 5'(HALF_MAX)) ? 6'(2 * HALF_MAX + 1)
                                                       : {in_half_length, 1'b1};
              sum_r   <= '0;
              i_r     <= '0;
              any_r   <= 1'b0;
              state_r <= S_STEP_GO;
            end
          end
        end
        S_STEP_GO: begin
          state_r <= S_STEP_WAIT;
        end
        S_STEP_WAIT: begin
          if (div_rsp.done) begin
            step_r  <= (div_rsp.quot[NW-1:24] != '0) ? 24'hFFFFFF : div_rsp.quot[23:0];
            state_r <= S_X_MUL;
          end
        end
        S_X_MUL: begin
          x_r     <= x_nxt;
          state_r <= S_SC_GO;
        end
        S_SC_GO: begin
          if (x_r == '0) begin
            c_r     <= CWID'(wfd_pkg::ONE_Q22);
            state_r <= S_WD_GO;
          end else begin
            state_r <= S_SC_WAIT;
          end
        end
        S_SC_WAIT: begin
          if (cor_rsp.done) begin
            sn_r    <= $signed(cor_rsp.sin_v);
            state_r <= S_SC_MUL;
          end
        end
        S_SC_MUL: begin
          sp_r    <= spp[65:18];
          state_r <= S_SD_GO;
        end
        S_SD_GO: begin
          neg_r   <= sp_r[47] ^ x_r[XW-1];
          state_r <= S_SD_WAIT;
        end
        S_SD_WAIT: begin
          if (div_rsp.done) begin
            c_r     <= CWID'(neg_r ? (~div_rsp.quot + 1'b1) : div_rsp.quot);
            state_r <= S_WD_GO;
          end
        end
        S_WD_GO: begin
          if (rr_r == 5'd0) begin
            w_r     <= 24'(wfd_pkg::ONE_Q22);
            state_r <= S_CW_MUL;
          end else begin
            state_r <= S_WD_WAIT;
          end
        end
        S_WD_WAIT: begin
          if (div_rsp.done) begin
            angle_r <= div_rsp.quot[22:0];
            state_r <= S_WC_GO;
          end
        end
        S_WC_GO: begin
          state_r <= S_WC_WAIT;
        end
        S_WC_WAIT: begin
          if (cor_rsp.done) begin
            w_r     <= wt[34] ? 24'd0 : wt[32:9];
            state_r <= S_CW_MUL;
          end
        end
        S_CW_MUL: begin
          cw_r    <= cw_nxt;
          state_r <= S_CW_WR;
        end
        S_CW_WR: begin
          sum_r <= sum_r + SW'(cw_r);
          if (i_r == n_r - 6'd1) begin
            i_r     <= '0;
            state_r <= S_Q_RD;
          end else begin
            i_r     <= i_r + 6'd1;
            state_r <= S_X_MUL;
          end
        end
        S_Q_RD: begin
          state_r <= S_Q_GO;
        end
        S_Q_GO: begin
          neg_r <= tap_s[23] ^ sum_r[SW-1];
          if (sum_r == '0) begin
            qv_r    <= '0;
            state_r <= S_Q_WR;
          end else begin
            state_r <= S_Q_WAIT;
          end
        end
        S_Q_WAIT: begin
          if (div_rsp.done) begin
            qv_r    <= qv_nxt;
            state_r <= S_Q_WR;
          end
        end
        S_Q_WR: begin
          if (qv_r != '0) begin
            if (!any_r) begin
              f_r <= i_r;
            end
            any_r <= 1'b1;
            l_r   <= i_r;
          end
          if (i_r == n_r - 6'd1) begin
            state_r <= S_TRIM;
          end else begin
            i_r     <= i_r + 6'd1;
            state_r <= S_Q_RD;
          end
        end
        S_TRIM: begin
          if (!any_r) begin
            out_tap_value_r   <= '0;
            out_tap_index_r   <= '0;
            out_tap_count_r   <= 6'd1;
            out_last_tap_r    <= 1'b1;
            out_bad_request_r <= 1'b0;
            out_valid_r       <= 1'b1;
            state_r           <= S_E_OUT;
          end else begin
            base_r  <= j_min;
            cnt_r   <= n_r - {j_min[4:0], 1'b0};
            idx_r   <= '0;
            state_r <= S_E_RD;
          end
        end
        S_E_RD: begin
          state_r <= S_E_WAIT;
        end
        S_E_WAIT: begin
          out_tap_value_r   <= qb_rdata;
          out_tap_index_r   <= idx_r;
          out_tap_count_r   <= cnt_r;
          out_last_tap_r    <= (idx_r == cnt_r - 6'd1);
          out_bad_request_r <= 1'b0;
          out_valid_r       <= 1'b1;
          state_r           <= S_E_OUT;
        end
        S_E_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_tap_r) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + 6'd1;
              state_r <= S_E_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_tap_value   = $signed(out_tap_value_r);
  assign out_tap_index   = out_tap_index_r;
  assign out_tap_count   = out_tap_count_r;
  assign out_last_tap    = out_last_tap_r;
  assign out_bad_request = out_bad_request_r;

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while a result beat is pending");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_STEP_WAIT || state_r == S_SD_WAIT ||
                      state_r == S_WD_WAIT || state_r == S_Q_WAIT))
    else $error("divider finished outside a wait state");

  a_cor_done: assert property (@(posedge clk) disable iff (!rst_n)
    cor_rsp.done |-> (state_r == S_SC_WAIT || state_r == S_WC_WAIT))
    else $error("CORDIC finished outside a wait state");

  a_bad_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_sample_rate == 32'd0) |=>
      (out_valid && out_bad_request && out_last_tap))
    else $error("zero sample rate did not give an error beat");

endmodule

`default_nettype wire
